>>> hdl/rhc_pkg.sv
// Shared types, constants and codes for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

  // Channel and result widths
  localparam int CHAN_W        = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_W         = 15;

  // Divider: 12 quotient bits are enough for the hue term (at most 60 degrees
  // in 1/64 units). Saturation uses the same divider with its numerator padded
  // by SAT_PAD zero bits.
  localparam int QUO_W       = 12;
  localparam int NUM_W       = CHAN_W + QUO_W;
  localparam int SAT_PAD     = QUO_W - CHAN_W;
  localparam int DIV_STEPS   = 2;
  localparam int DIV_STAGES  = QUO_W / DIV_STEPS;

  // Pipeline register count: sort, scale, divider stages, finish
  localparam int PIPE_STAGES = DIV_STAGES + 3;

  localparam logic [CHAN_W-1:0] CHAN_MAX  = {CHAN_W{1'b1}};
  localparam logic [QUO_W-1:0]  HUE_SCALE = QUO_W'(60 * (1 << HUE_FRAC_BITS));
  localparam logic [HUE_W-1:0]  HUE_GREEN = HUE_W'(120 * (1 << HUE_FRAC_BITS));
  localparam logic [HUE_W-1:0]  HUE_BLUE  = HUE_W'(240 * (1 << HUE_FRAC_BITS));
  localparam logic [HUE_W-1:0]  HUE_FULL  = HUE_W'(360 * (1 << HUE_FRAC_BITS));

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
    logic              gray;
  } hsv_t;

  // Result of the sorting stage
  typedef struct packed {
    sector_t            sector;
    logic [CHAN_W-1:0]  hi;
    logic [CHAN_W-1:0]  spread;
    logic signed [CHAN_W:0] diff;
  } sort_t;

  // One restoring-division lane: partial remainder, divisor, and a shared
  // word that shifts numerator bits out and quotient bits in.
  typedef struct packed {
    logic [CHAN_W-1:0] den;
    logic [CHAN_W-1:0] rem;
    logic [QUO_W-1:0]  bits;
  } div_lane_t;

  // Fields carried alongside the divisions
  typedef struct packed {
    sector_t           sector;
    logic              neg;
    logic              gray;
    logic [CHAN_W-1:0] brightness;
  } side_t;

  typedef struct packed {
    side_t     side;
    div_lane_t sat;
    div_lane_t hue;
  } stage_t;

endpackage

`default_nettype wire

>>> hdl/rhc_sort.sv
// Stage one: find the largest and smallest channel, the sector and the difference.
`default_nettype none

module rhc_sort (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            src_valid,
  input  wire rhc_pkg::pixel_t src,
  output logic                 vld,
  output rhc_pkg::sort_t       dst
);

  rhc_pkg::sort_t              dst_next;
  logic [rhc_pkg::CHAN_W-1:0]  lo;
  logic [rhc_pkg::CHAN_W-1:0]  op_a;
  logic [rhc_pkg::CHAN_W-1:0]  op_b;

  always_comb begin
    // red wins ties over green, green over blue
    if (src.red >= src.green && src.red >= src.blue) begin
      dst_next.sector = rhc_pkg::SECTOR_RED;
      dst_next.hi     = src.red;
      op_a            = src.green;
      op_b            = src.blue;
    end else if (src.green >= src.blue) begin
      dst_next.sector = rhc_pkg::SECTOR_GREEN;
      dst_next.hi     = src.green;
      op_a            = src.blue;
      op_b            = src.red;
    end else begin
      dst_next.sector = rhc_pkg::SECTOR_BLUE;
      dst_next.hi     = src.blue;
      op_a            = src.red;
      op_b            = src.green;
    end
    lo = (src.red <= src.green) ? src.red : src.green;
    if (src.blue < lo) begin
      lo = src.blue;
    end
    dst_next.spread = dst_next.hi - lo;
    dst_next.diff   = $signed({1'b0, op_a}) - $signed({1'b0, op_b});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && src_valid) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rhc_scale.sv
// Stage two: scale the numerators and load both division lanes.
`default_nettype none

module rhc_scale (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            src_valid,
  input  wire rhc_pkg::sort_t  src,
  output logic                 vld,
  output rhc_pkg::stage_t      dst
);

  rhc_pkg::stage_t             dst_next;
  logic [rhc_pkg::CHAN_W-1:0]  mag;
  logic [rhc_pkg::NUM_W-1:0]   hue_num;
  logic [rhc_pkg::NUM_W-1:0]   sat_num;

  always_comb begin
    mag = src.diff[rhc_pkg::CHAN_W] ? rhc_pkg::CHAN_W'(-src.diff)
                                    : src.diff[rhc_pkg::CHAN_W-1:0];
    hue_num = rhc_pkg::NUM_W'(mag) * rhc_pkg::NUM_W'(rhc_pkg::HUE_SCALE);
    sat_num = (rhc_pkg::NUM_W'(src.spread) * rhc_pkg::NUM_W'(rhc_pkg::CHAN_MAX))
              << rhc_pkg::SAT_PAD;

    dst_next.side.sector     = src.sector;
    dst_next.side.neg        = src.diff[rhc_pkg::CHAN_W];
    dst_next.side.gray       = (src.spread == '0);
    dst_next.side.brightness = src.hi;

    // top bits of each numerator start as the remainder, below the divisor unless it is zero
    dst_next.sat.den  = src.hi;
    dst_next.sat.rem  = sat_num[rhc_pkg::NUM_W-1:rhc_pkg::QUO_W];
    dst_next.sat.bits = sat_num[rhc_pkg::QUO_W-1:0];
    dst_next.hue.den  = src.spread;
    dst_next.hue.rem  = hue_num[rhc_pkg::NUM_W-1:rhc_pkg::QUO_W];
    dst_next.hue.bits = hue_num[rhc_pkg::QUO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && src_valid) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rhc_div_stage.sv
// One divider stage: DIV_STEPS restoring-division steps on both lanes.
`default_nettype none

module rhc_div_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            src_valid,
  input  wire rhc_pkg::stage_t src,
  output logic                 vld,
  output rhc_pkg::stage_t      dst
);

  rhc_pkg::stage_t dst_next;

  function automatic rhc_pkg::div_lane_t div_steps(input rhc_pkg::div_lane_t lane_in);
    rhc_pkg::div_lane_t           lane;
    logic [rhc_pkg::CHAN_W:0]     trial;
    logic                         take;
    lane = lane_in;
    for (int s = 0; s < rhc_pkg::DIV_STEPS; s++) begin
      trial     = {lane.rem, lane.bits[rhc_pkg::QUO_W-1]};
      take      = (trial >= {1'b0, lane.den});
      lane.rem  = take ? rhc_pkg::CHAN_W'(trial - {1'b0, lane.den})
                       : trial[rhc_pkg::CHAN_W-1:0];
      lane.bits = {lane.bits[rhc_pkg::QUO_W-2:0], take};
    end
    return lane;
  endfunction

  always_comb begin
    dst_next.side = src.side;
    dst_next.sat  = div_steps(src.sat);
    dst_next.hue  = div_steps(src.hue);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && src_valid) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rhc_finish.sv
// Last stage: apply the sector offset and sign, wrap, and hold the result.
`default_nettype none

module rhc_finish (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            src_valid,
  input  wire rhc_pkg::stage_t src,
  output logic                 vld,
  output rhc_pkg::hsv_t        dst
);

  rhc_pkg::hsv_t              dst_next;
  logic [rhc_pkg::QUO_W-1:0]  quo;
  logic [rhc_pkg::HUE_W-1:0]  base;

  always_comb begin
    quo = src.hue.bits;
    // a negative term in the red sector wraps by a full turn, unless it is zero
    unique case (src.side.sector)
      rhc_pkg::SECTOR_RED:   base = (src.side.neg && quo != '0) ? rhc_pkg::HUE_FULL : '0;
      rhc_pkg::SECTOR_GREEN: base = rhc_pkg::HUE_GREEN;
      rhc_pkg::SECTOR_BLUE:  base = rhc_pkg::HUE_BLUE;
      default:               base = '0;
    endcase

    dst_next.brightness = src.side.brightness;
    dst_next.gray       = src.side.gray;
    if (src.side.gray) begin
      dst_next.hue        = '0;
      dst_next.saturation = '0;
    end else begin
      dst_next.hue = src.side.neg ? base - rhc_pkg::HUE_W'(quo)
                                  : base + rhc_pkg::HUE_W'(quo);
      dst_next.saturation = src.sat.bits[rhc_pkg::QUO_W-1:rhc_pkg::SAT_PAD];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (advance) begin
      vld <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && src_valid) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rgb_to_hsv_convert_core.sv
// Top level of the pipelined RGB to HSV pixel converter.
`default_nettype none

// RGB to HSV converter for a pixel stream. It takes one pixel per clock
// while the input is not stalled and gives one result per pixel, in order.
// The depth is set by the hue and saturation dividers, which are restoring
// dividers spread over six stages of two quotient bits each; sorting of
// the channels and scaling of the numerators take one stage each ahead of
// them, and the final stage adds the sector offset and holds the result.
// Brightness is the largest channel, saturation is spread * 255 / largest
// (truncated), and hue is in 1/64 degree units from 0 to under 360
// degrees. A pixel whose channels are all equal is flagged gray, with hue
// and saturation zero. Each register stage advances when it is empty or
// the stage after it advances, so bubbles close up and the input is
// stalled only when every stage holds a pixel and the output transfer is
// stalled. No state survives between pixels.

module rgb_to_hsv_convert_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pixel_valid,
  output logic                 pixel_stall,
  input  wire rhc_pkg::pixel_t pixel,
  output logic                 hsv_valid,
  input  wire logic            hsv_stall,
  output rhc_pkg::hsv_t        hsv
);

  localparam int LAST = rhc_pkg::PIPE_STAGES - 1;

  // stage valids and advance enables, index 0 is the sorting stage
  logic [rhc_pkg::PIPE_STAGES-1:0] vld;
  logic [rhc_pkg::PIPE_STAGES-1:0] adv;

  rhc_pkg::sort_t  sort_data;
  rhc_pkg::stage_t div_data [rhc_pkg::DIV_STAGES+1];

  // advance the last stage when it is empty or its result is transferred,
  // every other stage when it is empty or the next one advances
  assign adv[LAST] = !vld[LAST] || !hsv_stall;
  for (genvar k = 0; k < LAST; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  assign pixel_stall = !adv[0];

  rhc_sort u_sort (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv[0]),
    .src_valid (pixel_valid),
    .src       (pixel),
    .vld       (vld[0]),
    .dst       (sort_data)
  );

  rhc_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv[1]),
    .src_valid (vld[0]),
    .src       (sort_data),
    .vld       (vld[1]),
    .dst       (div_data[0])
  );

  for (genvar d = 0; d < rhc_pkg::DIV_STAGES; d++) begin : g_div
    rhc_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .advance   (adv[d+2]),
      .src_valid (vld[d+1]),
      .src       (div_data[d]),
      .vld       (vld[d+2]),
      .dst       (div_data[d+1])
    );
  end

  rhc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .advance   (adv[LAST]),
    .src_valid (vld[LAST-1]),
    .src       (div_data[rhc_pkg::DIV_STAGES]),
    .vld       (vld[LAST]),
    .dst       (hsv)
  );

  assign hsv_valid = vld[LAST];

`ifndef SYNTHESIS
  // stall the input only with every stage full and the output held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (&vld) && hsv_stall)
    else $error("input stalled with room in the pipeline");

  a_gray_zero: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.gray |-> hsv.hue == '0 && hsv.saturation == '0)
    else $error("gray result with non-zero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |-> hsv.hue < rhc_pkg::HUE_FULL)
    else $error("hue beyond a full turn");

  a_black_gray: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.brightness == '0 |-> hsv.gray)
    else $error("black pixel not flagged gray");
`endif

endmodule

`default_nettype wire
